// ===== hw/rtl/spectrum_notch_reject_unit_assert.svh =====
// Assertion macros used by the notch-reject RTL.
`ifndef SPECTRUM_NOTCH_REJECT_UNIT_ASSERT_SVH
`define SPECTRUM_NOTCH_REJECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SNR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SNR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/snr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package snr_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int LEVEL_W    = 8;
    localparam int GAIN_W     = 17;
    localparam int REM_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int MAX_SIDE   = 1024;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_A_ROW  = 3'd1,
        REG_A_COL  = 3'd2,
        REG_B_ROW  = 3'd3,
        REG_B_COL  = 3'd4,
        REG_HEIGHT = 3'd5,
        REG_WIDTH  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_W-1:0]         pixel_row;
        logic [COORD_W-1:0]         pixel_col;
        logic signed [SAMPLE_W-1:0] sample_real;
        logic signed [SAMPLE_W-1:0] sample_imag;
        logic [LEVEL_W-1:0]         display_level;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_real;
        logic signed [SAMPLE_W-1:0] filtered_imag;
        logic [LEVEL_W-1:0]         filtered_level;
        logic [GAIN_W-1:0]          applied_gain;
    } t_out_item;

    // Partial state of one restoring division.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  den;
        logic [GAIN_W-1:0] quo;
    } t_div;

    // Sample data and mode that ride along the pipeline.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic [LEVEL_W-1:0]         level;
        logic                       mode;
        logic                       box_zero;
    } t_carry;

endpackage

`default_nettype wire

// ===== hw/rtl/spectrum_notch_reject_unit.sv =====
// Throughput: one item per cycle sustained unless the output stalls, which adds latency.
// The depth is set by the 17-stage restoring divider of the Butterworth notch factor.
// Each stage moves on when it is empty or its successor moves, so bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// box mode, both corners at zero, image height and width 1024.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_notch_reject_unit
    import snr_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  t_in_item         i_data,
    output logic                   o_valid,
    input  wire                    i_stall,
    output t_out_item              o_data,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

`include "spectrum_notch_reject_unit_assert.svh"

    localparam int NST    = 25;
    localparam int ST_DV0 = 5;
    localparam int NDIV   = 17;
    localparam int ST_GN  = ST_DV0 + NDIV;

    // Configuration registers.
    logic               r_mode;
    logic [COORD_W-1:0] r_ar, r_ac, r_br, r_bc;
    logic [SIZE_W-1:0]  r_h, r_w;
    logic [SIZE_W-1:0]  w_side;

    assign w_side = (i_cfg_data > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ar   <= '0;
            r_ac   <= '0;
            r_br   <= '0;
            r_bc   <= '0;
            r_h    <= SIZE_W'(MAX_SIDE);
            r_w    <= SIZE_W'(MAX_SIDE);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MODE:   r_mode <= i_cfg_data[0];
                REG_A_ROW:  r_ar   <= i_cfg_data[COORD_W-1:0];
                REG_A_COL:  r_ac   <= i_cfg_data[COORD_W-1:0];
                REG_B_ROW:  r_br   <= i_cfg_data[COORD_W-1:0];
                REG_B_COL:  r_bc   <= i_cfg_data[COORD_W-1:0];
                REG_HEIGHT: r_h    <= w_side;
                REG_WIDTH:  r_w    <= w_side;
                default: ;
            endcase
        end
    end

    // Stage valid bits and the enable chain that squeezes out bubbles.
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    assign w_en[NST-1] = !r_v[NST-1] || !i_stall;

    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NST-1];

    // Sample data travels alongside the gain computation.
    t_carry r_car [ST_GN];
    t_carry n_car1;
    logic [COORD_W-1:0] r_row0, r_col0;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_row0          <= i_data.pixel_row;
            r_col0          <= i_data.pixel_col;
            r_car[0].re     <= i_data.sample_real;
            r_car[0].im     <= i_data.sample_imag;
            r_car[0].level  <= i_data.display_level;
            r_car[0].mode   <= r_mode;
            r_car[0].box_zero <= 1'b0;
        end
    end

    generate
        for (k = 1; k < ST_GN; k++) begin : g_car
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_car[k] <= (k == 1) ? n_car1 : r_car[k-1];
                end
            end
        end
    endgenerate

    // Stage 1: offsets to both notch centers and the box membership test.
    logic signed [COORD_W+1:0] w_mar, w_mbr, w_mac, w_mbc;
    logic signed [COORD_W+1:0] w_row, w_col;
    logic signed [COORD_W+1:0] w_ra, w_rb, w_ca, w_cb;
    logic                      w_hit, w_hit_m;

    always_comb begin
        w_row = $signed({2'b00, r_row0});
        w_col = $signed({2'b00, r_col0});
        w_ra  = $signed({2'b00, r_ar});
        w_rb  = $signed({2'b00, r_br});
        w_ca  = $signed({2'b00, r_ac});
        w_cb  = $signed({2'b00, r_bc});
        w_mar = $signed({1'b0, r_h}) - w_ra;
        w_mbr = $signed({1'b0, r_h}) - w_rb;
        w_mac = $signed({1'b0, r_w}) - w_ca;
        w_mbc = $signed({1'b0, r_w}) - w_cb;
        w_hit = (w_row >= ((w_ra < w_rb) ? w_ra : w_rb))
             && (w_row <= ((w_ra < w_rb) ? w_rb : w_ra))
             && (w_col >= ((w_ca < w_cb) ? w_ca : w_cb))
             && (w_col <= ((w_ca < w_cb) ? w_cb : w_ca));
        w_hit_m = (w_row >= ((w_mar < w_mbr) ? w_mar : w_mbr))
               && (w_row <= ((w_mar < w_mbr) ? w_mbr : w_mar))
               && (w_col >= ((w_mac < w_mbc) ? w_mac : w_mbc))
               && (w_col <= ((w_mac < w_mbc) ? w_mbc : w_mac));
        n_car1 = r_car[0];
        n_car1.box_zero = w_hit || w_hit_m;
    end

    logic signed [COORD_W+1:0] r_dra, r_dca, r_drm, r_dcm, r_rr, r_rc;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_dra <= w_row - w_ra;
            r_dca <= w_col - w_ca;
            r_drm <= w_row - w_mar;
            r_dcm <= w_col - w_mac;
            r_rr  <= w_ra - w_rb;
            r_rc  <= w_ca - w_cb;
        end
    end

    // Stage 2: squared distances and squared radius.
    logic [23:0] r_d2a, r_d2m, r_r2;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_d2a <= 24'(r_dra * r_dra) + 24'(r_dca * r_dca);
            r_d2m <= 24'(r_drm * r_drm) + 24'(r_dcm * r_dcm);
            r_r2  <= 24'(r_rr * r_rr) + 24'(r_rc * r_rc);
        end
    end

    // Stage 3: fourth powers.
    logic [REM_W-1:0] r_d4a, r_d4m, r_r4;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_d4a <= r_d2a * r_d2a;
            r_d4m <= r_d2m * r_d2m;
            r_r4  <= r_r2 * r_r2;
        end
    end

    // Stage 4: divisors. Zero distance with zero radius gives a factor of one,
    // so that notch divides one by one.
    logic [REM_W-1:0] r_na, r_nm, r_dna, r_dnm;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            if (r_d4a == '0 && r_r4 == '0) begin
                r_na  <= REM_W'(1);
                r_dna <= REM_W'(1);
            end else begin
                r_na  <= r_d4a;
                r_dna <= r_d4a + r_r4;
            end
            if (r_d4m == '0 && r_r4 == '0) begin
                r_nm  <= REM_W'(1);
                r_dnm <= REM_W'(1);
            end else begin
                r_nm  <= r_d4m;
                r_dnm <= r_d4m + r_r4;
            end
        end
    end

    // Divider: the top quotient bit first, then one bit per stage.
    t_div r_dva [NDIV];
    t_div r_dvm [NDIV];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DV0]) begin
            r_dva[0].den <= r_dna;
            r_dva[0].quo <= GAIN_W'(r_na >= r_dna);
            r_dva[0].rem <= (r_na >= r_dna) ? (r_na - r_dna) : r_na;
            r_dvm[0].den <= r_dnm;
            r_dvm[0].quo <= GAIN_W'(r_nm >= r_dnm);
            r_dvm[0].rem <= (r_nm >= r_dnm) ? (r_nm - r_dnm) : r_nm;
        end
    end

    generate
        for (k = 1; k < NDIV; k++) begin : g_div
            t_div w_na, w_nm;

            snr_div_step u_step_a (.i_div(r_dva[k-1]), .o_div(w_na));
            snr_div_step u_step_m (.i_div(r_dvm[k-1]), .o_div(w_nm));

            always_ff @(posedge i_clk) begin
                if (w_en[ST_DV0+k]) begin
                    r_dva[k] <= w_na;
                    r_dvm[k] <= w_nm;
                end
            end
        end
    endgenerate

    // Gain stage: combine both notch factors, or take the box result.
    logic [2*GAIN_W-1:0]  w_fprod;
    logic [GAIN_W-1:0]    r_gain, r_gain2;
    logic [SAMPLE_W-1:0]  r_mre, r_mim;
    logic                 r_nre, r_nim, r_nre2, r_nim2;
    logic [LEVEL_W-1:0]   r_lv;

    assign w_fprod = r_dva[NDIV-1].quo * r_dvm[NDIV-1].quo;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_GN]) begin
            if (r_car[ST_GN-1].mode) begin
                r_gain <= w_fprod[GAIN_W+15:16];
            end else begin
                r_gain <= r_car[ST_GN-1].box_zero ? '0 : GAIN_ONE;
            end
            r_nre <= r_car[ST_GN-1].re[SAMPLE_W-1];
            r_nim <= r_car[ST_GN-1].im[SAMPLE_W-1];
            r_mre <= r_car[ST_GN-1].re[SAMPLE_W-1] ? -r_car[ST_GN-1].re : r_car[ST_GN-1].re;
            r_mim <= r_car[ST_GN-1].im[SAMPLE_W-1] ? -r_car[ST_GN-1].im : r_car[ST_GN-1].im;
            r_lv  <= r_car[ST_GN-1].level;
        end
    end

    // Product stage: magnitudes times gain.
    logic [SAMPLE_W+GAIN_W-1:0] r_pre, r_pim;
    logic [LEVEL_W+GAIN_W-1:0]  r_plv;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_GN+1]) begin
            r_pre   <= r_mre * r_gain;
            r_pim   <= r_mim * r_gain;
            r_plv   <= r_lv * r_gain;
            r_gain2 <= r_gain;
            r_nre2  <= r_nre;
            r_nim2  <= r_nim;
        end
    end

    // Output stage: drop the fraction and restore the sign.
    logic [SAMPLE_W:0] w_qre, w_qim;

    assign w_qre = r_pre[SAMPLE_W+GAIN_W-1:16];
    assign w_qim = r_pim[SAMPLE_W+GAIN_W-1:16];

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            o_data.filtered_real  <= r_nre2 ? SAMPLE_W'(-w_qre) : w_qre[SAMPLE_W-1:0];
            o_data.filtered_imag  <= r_nim2 ? SAMPLE_W'(-w_qim) : w_qim[SAMPLE_W-1:0];
            o_data.filtered_level <= r_plv[LEVEL_W+15:16];
            o_data.applied_gain   <= r_gain2;
        end
    end

    // A zero gain must silence every output field.
    `SNR_ASSERT_NOW(a_zero_gain, o_valid && o_data.applied_gain == '0, o_data.filtered_real == '0 && o_data.filtered_imag == '0 && o_data.filtered_level == '0, "zero gain with nonzero output")
    // The input is held off only when every stage holds an item.
    `SNR_ASSERT_NOW(a_stall_full, o_stall, &r_v, "input stalled with a bubble in the pipeline")
    // A notch factor never exceeds one.
    `SNR_ASSERT_NEXT(a_factor_max, r_v[ST_GN-1] && !w_en[ST_GN-1], r_dva[NDIV-1].quo <= GAIN_ONE && r_dvm[NDIV-1].quo <= GAIN_ONE, "notch factor above one")

endmodule

`default_nettype wire

// ===== hw/rtl/snr_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit of a restoring division: shift, compare, subtract.
module snr_div_step
    import snr_pkg::*;
(
    input  wire t_div i_div,
    output t_div o_div
);

    logic [REM_W-1:0] w_shift;
    logic             w_fit;

    assign w_shift = {i_div.rem[REM_W-2:0], 1'b0};
    assign w_fit   = (w_shift >= i_div.den);

    always_comb begin
        o_div.den = i_div.den;
        o_div.rem = w_fit ? (w_shift - i_div.den) : w_shift;
        o_div.quo = {i_div.quo[GAIN_W-2:0], w_fit};
    end

endmodule

`default_nettype wire
